// ----- rtl/ictf_pkg.sv -----
`default_nettype none
package ictf_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ANGLE_WIDTH_DEF  = 16;

    localparam int unsigned ATAN_LEN   = 24;
    localparam int unsigned ITER_W     = 5;
    localparam int unsigned SQRT_STEPS = 24;
    localparam int unsigned SQ_W       = 48;
    localparam int unsigned XY_W       = 36;
    localparam int unsigned Z_W        = 33;
    localparam int unsigned MUL_A_W    = 36;
    localparam int unsigned MUL_B_W    = 18;
    localparam int unsigned PROD_W     = 54;

    localparam logic [15:0]          BLEND_RESET = 16'd61604;
    localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 33'sd843314856;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_GYRO,
        MUL_ALPHA,
        MUL_BETA
    } mul_op_t;

    typedef struct packed {
        logic              load;
        logic              load_sq;
        logic              sqrt_step;
        logic              cordic_init;
        logic              cordic_sel;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
        mul_op_t           mul_op;
        logic              axis;
        logic              round_en;
        logic              commit;
    } ictf_cmd_t;

    // atan(2^-i), Q3.29
    function automatic logic signed [Z_W-1:0] atan_q29(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 33'sd421657428;
                5'd1:    v = 33'sd248918915;
                5'd2:    v = 33'sd131521918;
                5'd3:    v = 33'sd66762579;
                5'd4:    v = 33'sd33510843;
                5'd5:    v = 33'sd16771758;
                5'd6:    v = 33'sd8387925;
                5'd7:    v = 33'sd4194219;
                5'd8:    v = 33'sd2097141;
                5'd9:    v = 33'sd1048575;
                5'd10:   v = 33'sd524288;
                5'd11:   v = 33'sd262144;
                5'd12:   v = 33'sd131072;
                5'd13:   v = 33'sd65536;
                5'd14:   v = 33'sd32768;
                5'd15:   v = 33'sd16384;
                5'd16:   v = 33'sd8192;
                5'd17:   v = 33'sd4096;
                5'd18:   v = 33'sd2048;
                5'd19:   v = 33'sd1024;
                5'd20:   v = 33'sd512;
                5'd21:   v = 33'sd256;
                5'd22:   v = 33'sd128;
                5'd23:   v = 33'sd64;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/imu_complementary_tilt_filter_core.sv -----
// Roll/pitch complementary tilt filter.
// Input channel (in_valid/in_ready): one word per IMU sample holding
// accel_x/y/z, rate_x/y (Q5.11 rad/s) and time_step (Q0.16 s).
// Output channel (out_valid/out_ready): roll_angle and pitch_angle,
// signed Q3.(ANGLE_WIDTH-3) radians, saturated; one word per input word.
// cfg_we/cfg_wdata write the gyro weight (Q0.16, reset 0.94); write only
// while idle.
// One word is processed at a time. After an input is accepted the core
// runs a setup state, 24 square-root steps, and two N-step CORDIC passes,
// N = min(CORDIC_STEPS, 24), each after its own setup state, on one shared
// rotator; then integration, blending and rounding per axis on one shared
// multiplier, and a commit state that holds while a word is pending.
// in_ready rises together with out_valid; a new word waits for the commit.
// The finished word sits in the output register; the next sample is
// accepted and processed while it waits, and that sample holds in its
// final step until the pending word is taken.
// Reset clears the stored angles to zero, the weight to 0.94, and drops
// any word in flight.
`default_nettype none
module imu_complementary_tilt_filter_core #(
    parameter int unsigned CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF,
    parameter int unsigned ANGLE_WIDTH  = ictf_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [15:0]       accel_x,
    input  wire logic signed [15:0]       accel_y,
    input  wire logic signed [15:0]       accel_z,
    input  wire logic signed [15:0]       rate_x,
    input  wire logic signed [15:0]       rate_y,
    input  wire logic [15:0]              time_step,
    input  wire logic                     cfg_we,
    input  wire logic [15:0]              cfg_wdata,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic signed [ANGLE_WIDTH-1:0] pitch_angle
);
    ictf_pkg::ictf_cmd_t cmd;

    ictf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    ictf_datapath #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .rate_x     (rate_x),
        .rate_y     (rate_y),
        .time_step  (time_step),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .roll_angle (roll_angle),
        .pitch_angle(pitch_angle)
    );

endmodule
`default_nettype wire

// ----- rtl/ictf_datapath.sv -----
`default_nettype none
module ictf_datapath #(
    parameter int unsigned ANGLE_WIDTH = ictf_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire ictf_pkg::ictf_cmd_t      cmd,
    input  wire logic signed [15:0]       accel_x,
    input  wire logic signed [15:0]       accel_y,
    input  wire logic signed [15:0]       accel_z,
    input  wire logic signed [15:0]       rate_x,
    input  wire logic signed [15:0]       rate_y,
    input  wire logic [15:0]              time_step,
    input  wire logic                     cfg_we,
    input  wire logic [15:0]              cfg_wdata,
    output logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic signed [ANGLE_WIDTH-1:0] pitch_angle
);
    localparam int unsigned XY_W   = ictf_pkg::XY_W;
    localparam int unsigned Z_W    = ictf_pkg::Z_W;
    localparam int unsigned SQ_W   = ictf_pkg::SQ_W;
    localparam int unsigned PROD_W = ictf_pkg::PROD_W;
    localparam int unsigned UP_SH  = 32 - ANGLE_WIDTH;
    localparam int unsigned RND_SH = 48 - ANGLE_WIDTH;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    logic signed [15:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg;
    logic [15:0]        dt_reg;
    logic [15:0]        blend_reg;

    logic [SQ_W-1:0] sq_n_reg, sq_n_next, sq_r_reg, sq_r_next, sq_b_reg, sq_b_next;

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next, tilt_roll_reg, tilt_roll_next;
    logic                   zero_reg, zero_next;

    logic signed [XY_W-1:0]   gyro_reg, gyro_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;

    logic signed [ANGLE_WIDTH-1:0] rnd_roll_reg, rnd_roll_next, rnd_pitch_reg, rnd_pitch_next;
    logic signed [ANGLE_WIDTH-1:0] last_roll_reg, last_roll_next;
    logic signed [ANGLE_WIDTH-1:0] last_pitch_reg, last_pitch_next;

    logic signed [31:0]     ay_sq, az_sq;
    logic [SQ_W-1:0]        sq_trial;
    logic signed [XY_W-1:0] x0, y0, dx, dy;
    logic signed [Z_W-1:0]  angle_sel, z_pitch;
    logic signed [ictf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ictf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod, rnd_full, rnd_sat;
    logic signed [XY_W-1:0]   last_ext;
    logic signed [ANGLE_WIDTH-1:0] last_sel;

    assign ay_sq    = ay_reg * ay_reg;
    assign az_sq    = az_reg * az_reg;
    assign sq_trial = sq_r_reg + sq_b_reg;

    always_comb
    begin
        sq_n_next = sq_n_reg;
        sq_r_next = sq_r_reg;
        sq_b_next = sq_b_reg;
        if (cmd.load_sq)
        begin
            sq_n_next = SQ_W'({32'(unsigned'(ay_sq) + unsigned'(az_sq)), 16'h0});
            sq_r_next = '0;
            sq_b_next = SQ_W'(1) << 46;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_n_reg >= sq_trial)
            begin
                sq_n_next = sq_n_reg - sq_trial;
                sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
            end
            else
            begin
                sq_r_next = sq_r_reg >> 1;
            end
            sq_b_next = sq_b_reg >> 2;
        end
    end

    assign z_pitch = zero_reg ? '0 : z_reg;

    always_comb
    begin
        if (cmd.cordic_sel)
        begin
            y0 = -(XY_W'(ax_reg) <<< 16);
            x0 = XY_W'({sq_r_reg[23:0], 8'h0});
        end
        else
        begin
            y0 = XY_W'(ay_reg) <<< 16;
            x0 = XY_W'(az_reg) <<< 16;
        end
        dx = y_reg >>> cmd.iter;
        dy = x_reg >>> cmd.iter;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        tilt_roll_next = tilt_roll_reg;
        if (cmd.cordic_init)
        begin
            zero_next = (x0 == '0) && (y0 == '0);
            if (cmd.cordic_sel)
                tilt_roll_next = z_pitch;
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0;
                    y_next = -x0;
                    z_next = ictf_pkg::HALF_PI_Q29;
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    z_next = -ictf_pkg::HALF_PI_Q29;
                end
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ictf_pkg::atan_q29(cmd.iter);
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ictf_pkg::atan_q29(cmd.iter);
            end
        end
    end

    assign last_sel  = cmd.axis ? last_pitch_reg : last_roll_reg;
    assign last_ext  = XY_W'(last_sel) <<< UP_SH;
    assign angle_sel = cmd.axis ? z_pitch : tilt_roll_reg;

    always_comb
    begin
        case (cmd.mul_op)
            ictf_pkg::MUL_GYRO:
            begin
                mul_a = XY_W'(cmd.axis ? ry_reg : rx_reg);
                mul_b = {2'b00, dt_reg};
            end
            ictf_pkg::MUL_ALPHA:
            begin
                mul_a = gyro_reg;
                mul_b = {2'b00, blend_reg};
            end
            ictf_pkg::MUL_BETA:
            begin
                mul_a = XY_W'(angle_sel);
                mul_b = {1'b0, 17'(17'h10000 - {1'b0, blend_reg})};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        gyro_next = gyro_reg;
        acc_next  = acc_reg;
        case (cmd.mul_op)
            ictf_pkg::MUL_GYRO:  gyro_next = last_ext + XY_W'(prod <<< 2);
            ictf_pkg::MUL_ALPHA: acc_next  = prod;
            ictf_pkg::MUL_BETA:  acc_next  = acc_reg + prod;
            default:             acc_next  = acc_reg;
        endcase
    end

    always_comb
    begin
        rnd_full = (acc_reg + RND_HALF) >>> RND_SH;
        if (rnd_full > SAT_HI)
            rnd_sat = SAT_HI;
        else if (rnd_full < SAT_LO)
            rnd_sat = SAT_LO;
        else
            rnd_sat = rnd_full;
        rnd_roll_next  = rnd_roll_reg;
        rnd_pitch_next = rnd_pitch_reg;
        if (cmd.round_en)
        begin
            if (cmd.axis)
                rnd_pitch_next = ANGLE_WIDTH'(rnd_sat);
            else
                rnd_roll_next = ANGLE_WIDTH'(rnd_sat);
        end
        last_roll_next  = cmd.commit ? rnd_roll_reg : last_roll_reg;
        last_pitch_next = cmd.commit ? rnd_pitch_reg : last_pitch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg      <= ictf_pkg::BLEND_RESET;
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                blend_reg <= cfg_wdata;
            last_roll_reg  <= last_roll_next;
            last_pitch_reg <= last_pitch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            rx_reg <= rate_x;
            ry_reg <= rate_y;
            dt_reg <= time_step;
        end
        sq_n_reg      <= sq_n_next;
        sq_r_reg      <= sq_r_next;
        sq_b_reg      <= sq_b_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        zero_reg      <= zero_next;
        tilt_roll_reg <= tilt_roll_next;
        gyro_reg      <= gyro_next;
        acc_reg       <= acc_next;
        rnd_roll_reg  <= rnd_roll_next;
        rnd_pitch_reg <= rnd_pitch_next;
    end

    assign roll_angle  = last_roll_reg;
    assign pitch_angle = last_pitch_reg;

endmodule
`default_nettype wire

// ----- rtl/ictf_ctrl.sv -----
`default_nettype none
module ictf_ctrl #(
    parameter int unsigned CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ictf_pkg::ictf_cmd_t  cmd
);
    localparam int unsigned N_ROT = (CORDIC_STEPS > ictf_pkg::ATAN_LEN) ?
                                    ictf_pkg::ATAN_LEN : CORDIC_STEPS;
    localparam logic [ictf_pkg::ITER_W-1:0] ROT_LAST  = ictf_pkg::ITER_W'(N_ROT - 1);
    localparam logic [ictf_pkg::ITER_W-1:0] SQRT_LAST =
        ictf_pkg::ITER_W'(ictf_pkg::SQRT_STEPS - 1);

    typedef enum logic [4:0] {
        IDLE, SQ_INIT, SQRT, CI_R, CR_R, CI_P, CR_P,
        R_GYRO, R_ALPHA, R_BETA, R_ROUND,
        P_GYRO, P_ALPHA, P_BETA, P_ROUND, COMMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [ictf_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          accept, can_commit;

    assign in_ready   = (state_reg == IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign can_commit = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.mul_op      = ictf_pkg::MUL_NONE;
        cmd.iter        = iter_reg;
        cmd.load        = accept;
        state_next      = state_reg;
        iter_next       = iter_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                    state_next = SQ_INIT;
            end
            SQ_INIT:
            begin
                cmd.load_sq = 1'b1;
                iter_next   = '0;
                state_next  = SQRT;
            end
            SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 1'b1;
                if (iter_reg == SQRT_LAST)
                    state_next = CI_R;
            end
            CI_R:
            begin
                cmd.cordic_init = 1'b1;
                iter_next       = '0;
                state_next      = CR_R;
            end
            CR_R:
            begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + 1'b1;
                if (iter_reg == ROT_LAST)
                    state_next = CI_P;
            end
            CI_P:
            begin
                cmd.cordic_init = 1'b1;
                cmd.cordic_sel  = 1'b1;
                iter_next       = '0;
                state_next      = CR_P;
            end
            CR_P:
            begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + 1'b1;
                if (iter_reg == ROT_LAST)
                    state_next = R_GYRO;
            end
            R_GYRO:
            begin
                cmd.mul_op = ictf_pkg::MUL_GYRO;
                state_next = R_ALPHA;
            end
            R_ALPHA:
            begin
                cmd.mul_op = ictf_pkg::MUL_ALPHA;
                state_next = R_BETA;
            end
            R_BETA:
            begin
                cmd.mul_op = ictf_pkg::MUL_BETA;
                state_next = R_ROUND;
            end
            R_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = P_GYRO;
            end
            P_GYRO:
            begin
                cmd.axis   = 1'b1;
                cmd.mul_op = ictf_pkg::MUL_GYRO;
                state_next = P_ALPHA;
            end
            P_ALPHA:
            begin
                cmd.axis   = 1'b1;
                cmd.mul_op = ictf_pkg::MUL_ALPHA;
                state_next = P_BETA;
            end
            P_BETA:
            begin
                cmd.axis   = 1'b1;
                cmd.mul_op = ictf_pkg::MUL_BETA;
                state_next = P_ROUND;
            end
            P_ROUND:
            begin
                cmd.axis     = 1'b1;
                cmd.round_en = 1'b1;
                state_next   = COMMIT;
            end
            COMMIT:
            begin
                if (can_commit)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise out_valid");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == SQ_INIT))
        else $error("accepted word did not start processing");

    a_rot_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_step |-> (iter_reg <= ROT_LAST))
        else $error("rotation index out of range");

endmodule
`default_nettype wire
